// ----- hw/rtl/twd_pkg.sv -----
// shared types, codes and width tables of the terminal display width block
package twd_pkg;

  localparam int unsigned WIDTH_COUNT_BITS = 24;
  localparam int unsigned OUT_BITS = 24;
  localparam int unsigned ADD_BITS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_CSI     = 3'd2;
  localparam logic [2:0] MODE_OSC     = 3'd3;
  localparam logic [2:0] MODE_OSC_ESC = 3'd4;

  localparam logic [7:0] ESC_CHAR = 8'h1B;
  localparam logic [7:0] BEL_CHAR = 8'h07;
  localparam logic [7:0] CSI_CHAR = 8'h5B;
  localparam logic [7:0] OSC_CHAR = 8'h5D;
  localparam logic [7:0] ST_CHAR  = 8'h5C;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] ZWJ_CP       = 21'h00200D;
  localparam logic [20:0] REGIONAL_LO  = 21'h1F1E6;
  localparam logic [20:0] REGIONAL_HI  = 21'h1F1FF;
  localparam logic [20:0] SKIN_LO      = 21'h1F3FB;
  localparam logic [20:0] SKIN_HI      = 21'h1F3FF;
  localparam logic [20:0] VSEL_LO      = 21'h0FE00;
  localparam logic [20:0] VSEL_HI      = 21'h0FE0F;

  // one entry of the queue between decoder and accumulator
  typedef struct packed {
    logic                last;
    logic [ADD_BITS-1:0] add;
  } cmd_t;

  function automatic logic sp(logic [20:0] u, logic [20:0] lo, logic [20:0] hi);
    return (u >= lo) && (u <= hi);
  endfunction

  function automatic logic is_zero_width(logic [20:0] u);
    return
      sp(u,21'h0000,21'h001F) | sp(u,21'h200B,21'h200F) | sp(u,21'h2028,21'h202E) |
      sp(u,21'h2060,21'h2064) | sp(u,21'hFEFF,21'hFEFF) | sp(u,21'hFFF9,21'hFFFB) |
      sp(u,21'hE0100,21'hE01EF) |
      sp(u,21'h0300,21'h036F) | sp(u,21'h0483,21'h0489) | sp(u,21'h0591,21'h05BD) |
      sp(u,21'h0610,21'h061A) | sp(u,21'h064B,21'h065F) | sp(u,21'h0670,21'h0670) |
      sp(u,21'h06D6,21'h06DC) | sp(u,21'h06DF,21'h06E4) | sp(u,21'h06E7,21'h06E8) |
      sp(u,21'h06EA,21'h06ED) | sp(u,21'h0711,21'h0711) | sp(u,21'h0730,21'h074A) |
      sp(u,21'h07A6,21'h07B0) | sp(u,21'h0900,21'h0902) | sp(u,21'h093A,21'h093C) |
      sp(u,21'h0941,21'h0948) | sp(u,21'h0951,21'h0957) | sp(u,21'h0962,21'h0963) |
      sp(u,21'h0981,21'h0981) | sp(u,21'h09BC,21'h09BC) | sp(u,21'h09C1,21'h09C4) |
      sp(u,21'h09CD,21'h09CD) | sp(u,21'h09E2,21'h09E3) | sp(u,21'h0A01,21'h0A02) |
      sp(u,21'h0A3C,21'h0A3C) | sp(u,21'h0A41,21'h0A42) | sp(u,21'h0A47,21'h0A48) |
      sp(u,21'h0A4B,21'h0A4D) | sp(u,21'h0A70,21'h0A71) | sp(u,21'h0A81,21'h0A82) |
      sp(u,21'h0ABC,21'h0ABC) | sp(u,21'h0AC1,21'h0AC5) | sp(u,21'h0AC7,21'h0AC8) |
      sp(u,21'h0ACD,21'h0ACD) | sp(u,21'h0AE2,21'h0AE3) | sp(u,21'h0B01,21'h0B01) |
      sp(u,21'h0B3C,21'h0B3C) | sp(u,21'h0B3F,21'h0B3F) | sp(u,21'h0B41,21'h0B44) |
      sp(u,21'h0B4D,21'h0B4D) | sp(u,21'h0B56,21'h0B56) | sp(u,21'h0B62,21'h0B63) |
      sp(u,21'h0B82,21'h0B82) | sp(u,21'h0BC0,21'h0BC0) | sp(u,21'h0BCD,21'h0BCD) |
      sp(u,21'h0C3E,21'h0C40) | sp(u,21'h0C46,21'h0C48) | sp(u,21'h0C4A,21'h0C4D) |
      sp(u,21'h0C55,21'h0C56) | sp(u,21'h0C62,21'h0C63) | sp(u,21'h0CBC,21'h0CBC) |
      sp(u,21'h0CBF,21'h0CBF) | sp(u,21'h0CC6,21'h0CC6) | sp(u,21'h0CCC,21'h0CCD) |
      sp(u,21'h0CE2,21'h0CE3) | sp(u,21'h0D41,21'h0D44) | sp(u,21'h0D4D,21'h0D4D) |
      sp(u,21'h0D62,21'h0D63) | sp(u,21'h0DCA,21'h0DCA) | sp(u,21'h0DD2,21'h0DD4) |
      sp(u,21'h0DD6,21'h0DD6) | sp(u,21'h0E31,21'h0E31) | sp(u,21'h0E34,21'h0E3A) |
      sp(u,21'h0E47,21'h0E4E) | sp(u,21'h0EB1,21'h0EB1) | sp(u,21'h0EB4,21'h0EB9) |
      sp(u,21'h0EBB,21'h0EBC) | sp(u,21'h0EC8,21'h0ECD) | sp(u,21'h0F18,21'h0F19) |
      sp(u,21'h0F35,21'h0F35) | sp(u,21'h0F37,21'h0F37) | sp(u,21'h0F39,21'h0F39) |
      sp(u,21'h0F71,21'h0F7E) | sp(u,21'h0F80,21'h0F84) | sp(u,21'h0F86,21'h0F87) |
      sp(u,21'h0F90,21'h0F97) | sp(u,21'h0F99,21'h0FBC) | sp(u,21'h0FC6,21'h0FC6) |
      sp(u,21'h102D,21'h1030) | sp(u,21'h1032,21'h1037) | sp(u,21'h1039,21'h103A) |
      sp(u,21'h103D,21'h103E) | sp(u,21'h1058,21'h1059) | sp(u,21'h105E,21'h1060) |
      sp(u,21'h1071,21'h1074) | sp(u,21'h1082,21'h1082) | sp(u,21'h1085,21'h1086) |
      sp(u,21'h108D,21'h108D) | sp(u,21'h109D,21'h109D) | sp(u,21'h135D,21'h135F) |
      sp(u,21'h1712,21'h1714) | sp(u,21'h1732,21'h1734) | sp(u,21'h1752,21'h1753) |
      sp(u,21'h1772,21'h1773) | sp(u,21'h17B4,21'h17B5) | sp(u,21'h17B7,21'h17BD) |
      sp(u,21'h17C6,21'h17C6) | sp(u,21'h17C9,21'h17D3) | sp(u,21'h17DD,21'h17DD) |
      sp(u,21'h180B,21'h180D) | sp(u,21'h1885,21'h1886) | sp(u,21'h18A9,21'h18A9) |
      sp(u,21'h1920,21'h1922) | sp(u,21'h1927,21'h1928) | sp(u,21'h1932,21'h1932) |
      sp(u,21'h1939,21'h193B) | sp(u,21'h1A17,21'h1A18) | sp(u,21'h1A56,21'h1A56) |
      sp(u,21'h1A58,21'h1A5E) | sp(u,21'h1A60,21'h1A60) | sp(u,21'h1A62,21'h1A62) |
      sp(u,21'h1A65,21'h1A6C) | sp(u,21'h1A73,21'h1A7C) | sp(u,21'h1A7F,21'h1A7F) |
      sp(u,21'h1B00,21'h1B03) | sp(u,21'h1B34,21'h1B34) | sp(u,21'h1B36,21'h1B3A) |
      sp(u,21'h1B3C,21'h1B3C) | sp(u,21'h1B42,21'h1B42) | sp(u,21'h1B6B,21'h1B73) |
      sp(u,21'h1B80,21'h1B81) | sp(u,21'h1BA2,21'h1BA5) | sp(u,21'h1BA8,21'h1BA9) |
      sp(u,21'h1BAB,21'h1BAD) | sp(u,21'h1BE6,21'h1BE6) | sp(u,21'h1BE8,21'h1BE9) |
      sp(u,21'h1BED,21'h1BED) | sp(u,21'h1BEF,21'h1BF1) | sp(u,21'h1C2C,21'h1C33) |
      sp(u,21'h1C36,21'h1C37) | sp(u,21'h1CD0,21'h1CD2) | sp(u,21'h1CD4,21'h1CE0) |
      sp(u,21'h1CE2,21'h1CE8) | sp(u,21'h1CED,21'h1CED) | sp(u,21'h1CF4,21'h1CF4) |
      sp(u,21'h1DC0,21'h1DFF) | sp(u,21'h20D0,21'h20F0) | sp(u,21'h2CEF,21'h2CF1) |
      sp(u,21'h2D7F,21'h2D7F) | sp(u,21'h2DE0,21'h2DFF) | sp(u,21'hA66F,21'hA672) |
      sp(u,21'hA674,21'hA67D) | sp(u,21'hA69E,21'hA69F) | sp(u,21'hA6F0,21'hA6F1) |
      sp(u,21'hA802,21'hA802) | sp(u,21'hA806,21'hA806) | sp(u,21'hA80B,21'hA80B) |
      sp(u,21'hA825,21'hA826) | sp(u,21'hA8C4,21'hA8C5) | sp(u,21'hA8E0,21'hA8F1) |
      sp(u,21'hA926,21'hA92D) | sp(u,21'hA947,21'hA951) | sp(u,21'hA980,21'hA982) |
      sp(u,21'hA9B3,21'hA9B3) | sp(u,21'hA9B6,21'hA9B9) | sp(u,21'hA9BC,21'hA9BC) |
      sp(u,21'hAA29,21'hAA2E) | sp(u,21'hAA31,21'hAA32) | sp(u,21'hAA35,21'hAA36) |
      sp(u,21'hAA43,21'hAA43) | sp(u,21'hAA4C,21'hAA4C) | sp(u,21'hAAB0,21'hAAB0) |
      sp(u,21'hAAB2,21'hAAB4) | sp(u,21'hAAB7,21'hAAB8) | sp(u,21'hAABE,21'hAABF) |
      sp(u,21'hAAC1,21'hAAC1) | sp(u,21'hAAEC,21'hAAED) | sp(u,21'hAAF6,21'hAAF6) |
      sp(u,21'hABE5,21'hABE5) | sp(u,21'hABE8,21'hABE8) | sp(u,21'hABED,21'hABED) |
      sp(u,21'hFB1E,21'hFB1E) | sp(u,21'hFE00,21'hFE0F) | sp(u,21'hFE20,21'hFE2F);
  endfunction

  function automatic logic is_wide(logic [20:0] u);
    return
      sp(u,21'h1100,21'h115F) | sp(u,21'h2329,21'h232A) | sp(u,21'h2E80,21'h303E) |
      sp(u,21'h3041,21'h33BF) | sp(u,21'h3400,21'h4DBF) | sp(u,21'h4E00,21'hA4CF) |
      sp(u,21'hA960,21'hA97C) | sp(u,21'hAC00,21'hD7A3) | sp(u,21'hF900,21'hFAFF) |
      sp(u,21'hFE10,21'hFE19) | sp(u,21'hFE30,21'hFE6F) | sp(u,21'hFF01,21'hFF60) |
      sp(u,21'hFFE0,21'hFFE6) | sp(u,21'h1B000,21'h1B2FF) | sp(u,21'h1F000,21'h1FAFF) |
      sp(u,21'h20000,21'h2FFFD) | sp(u,21'h30000,21'h3FFFD);
  endfunction

endpackage

// ----- hw/rtl/twd_front.sv -----
// byte decoder: escape filter, utf-8 assembly and cluster tracking
module twd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    text_byte_i,
  input  logic          byte_present_i,
  input  logic          last_byte_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output twd_pkg::cmd_t cmd_o
);
  import twd_pkg::*;

  typedef struct packed {
    logic [1:0] cols;
    logic       regional;
    logic       silent;
    logic       zwj;
  } unit_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [20:0]         part;
    logic [1:0]          need;
    logic [1:0]          taken;
    logic                open;
    logic [1:0]          base;
    logic                joined;
    logic                rwait;
    logic                paired;
    logic                ajoin;
    logic [ADD_BITS-1:0] add;
  } fs_t;

  localparam unit_t REPL_UNIT = '{cols: 2'd1, regional: 1'b0, silent: 1'b0, zwj: 1'b0};
  localparam unit_t ESC_UNIT  = '{cols: 2'd0, regional: 1'b0, silent: 1'b0, zwj: 1'b0};

  function automatic fs_t close_cl(fs_t s);
    s.add    = s.add + ADD_BITS'((s.joined || s.paired) ? 2'd2 : s.base);
    s.open   = 1'b0;
    s.base   = 2'd0;
    s.joined = 1'b0;
    s.rwait  = 1'b0;
    s.paired = 1'b0;
    s.ajoin  = 1'b0;
    return s;
  endfunction

  function automatic fs_t take_unit(fs_t s, unit_t a);
    logic done;
    done = 1'b0;
    if (s.open) begin
      if (s.ajoin) begin
        s.ajoin = 1'b0;
        s.rwait = 1'b0;
        done    = 1'b1;
      end else begin
        if (s.rwait) begin
          s.rwait = 1'b0;
          if (a.regional) begin
            s.paired = 1'b1;
            done     = 1'b1;
          end
        end
        if (!done && a.silent) begin
          done = 1'b1;
        end
        if (!done && a.zwj) begin
          s.joined = 1'b1;
          s.ajoin  = 1'b1;
          done     = 1'b1;
        end
        if (!done) begin
          s = close_cl(s);
        end
      end
    end
    if (!done) begin
      s.open   = 1'b1;
      s.base   = a.cols;
      s.rwait  = a.regional;
      s.paired = 1'b0;
      s.joined = 1'b0;
      s.ajoin  = 1'b0;
    end
    return s;
  endfunction

  function automatic fs_t emit_invalid(fs_t s, logic [2:0] cnt);
    s.part  = '0;
    s.need  = 2'd0;
    s.taken = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cnt) begin
        s = take_unit(s, REPL_UNIT);
      end
    end
    return s;
  endfunction

  function automatic fs_t text_in(fs_t s, logic [7:0] b, unit_t ca);
    logic        done;
    logic [2:0]  len;
    logic [20:0] c;
    logic [20:0] least;
    unit_t       au;
    done  = 1'b0;
    len   = 3'd0;
    c     = '0;
    least = '0;
    au    = '{cols: (b < 8'h20) ? 2'd0 : 2'd1, regional: 1'b0, silent: 1'b0, zwj: 1'b0};
    if (s.need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        c      = {s.part[14:0], b[5:0]};
        s.part = c;
        s.need = s.need - 2'd1;
        if (s.need == 2'd0) begin
          len = 3'(s.taken) + 3'd1;
          case (len)
            3'd2:    least = 21'h80;
            3'd3:    least = 21'h800;
            default: least = 21'h10000;
          endcase
          if (c >= least && c <= CP_MAX && !(c >= SURR_LO && c <= SURR_HI)) begin
            s.part  = '0;
            s.taken = 2'd0;
            s      = take_unit(s, ca);
          end else begin
            s = emit_invalid(s, len);
          end
        end else begin
          s.taken = s.taken + 2'd1;
        end
        done = 1'b1;
      end else begin
        s = emit_invalid(s, 3'(s.taken));
      end
    end
    if (!done) begin
      if (b < 8'h80) begin
        if (b == ESC_CHAR && !(s.open && s.ajoin)) begin
          if (s.open) begin
            s = close_cl(s);
          end
          s.mode = MODE_ESC;
        end else begin
          s = take_unit(s, au);
        end
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        s = take_unit(s, REPL_UNIT);
      end else begin
        s.taken = 2'd1;
        if (b < 8'hE0) begin
          s.part = 21'(b[4:0]);
          s.need = 2'd1;
        end else if (b < 8'hF0) begin
          s.part = 21'(b[3:0]);
          s.need = 2'd2;
        end else begin
          s.part = 21'(b[2:0]);
          s.need = 2'd3;
        end
      end
    end
    return s;
  endfunction

  function automatic fs_t osc_in(fs_t s, logic [7:0] b);
    if (b == BEL_CHAR) begin
      s.mode = MODE_TEXT;
    end else if (b == ESC_CHAR) begin
      s.mode = MODE_OSC_ESC;
    end else begin
      s.mode = MODE_OSC;
    end
    return s;
  endfunction

  fs_t         st_q, st_d;
  fs_t         s;
  logic [20:0] cand;
  unit_t       cand_u;
  logic        accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // attributes of the code point a continuation byte would complete
  always_comb begin
    cand          = {st_q.part[14:0], text_byte_i[5:0]};
    cand_u.cols   = is_zero_width(cand) ? 2'd0 : (is_wide(cand) ? 2'd2 : 2'd1);
    cand_u.regional = (cand >= REGIONAL_LO) && (cand <= REGIONAL_HI);
    cand_u.silent = ((cand >= VSEL_LO) && (cand <= VSEL_HI)) ||
                    ((cand >= SKIN_LO) && (cand <= SKIN_HI));
    cand_u.zwj    = (cand == ZWJ_CP);
  end

  always_comb begin
    s     = st_q;
    s.add = '0;
    if (byte_present_i) begin
      case (st_q.mode)
        MODE_ESC: begin
          if (text_byte_i == CSI_CHAR) begin
            s.mode = MODE_CSI;
          end else if (text_byte_i == OSC_CHAR) begin
            s.mode = MODE_OSC;
          end else begin
            s.mode = MODE_TEXT;
            s      = take_unit(s, ESC_UNIT);
            s      = text_in(s, text_byte_i, cand_u);
          end
        end
        MODE_CSI: begin
          if (text_byte_i >= CSI_FINAL_LO && text_byte_i <= CSI_FINAL_HI) begin
            s.mode = MODE_TEXT;
          end
        end
        MODE_OSC: begin
          s = osc_in(s, text_byte_i);
        end
        MODE_OSC_ESC: begin
          if (text_byte_i == ST_CHAR) begin
            s.mode = MODE_TEXT;
          end else begin
            s = osc_in(s, text_byte_i);
          end
        end
        default: begin
          s.mode = MODE_TEXT;
          s      = text_in(s, text_byte_i, cand_u);
        end
      endcase
    end
    if (last_byte_i) begin
      if (s.mode == MODE_ESC) begin
        s.mode = MODE_TEXT;
        s      = take_unit(s, ESC_UNIT);
      end
      if (s.need != 2'd0) begin
        s = emit_invalid(s, 3'(s.taken));
      end
      if (s.open) begin
        s = close_cl(s);
      end
    end
    st_d = st_q;
    if (accept) begin
      st_d     = s;
      st_d.add = '0;
      if (last_byte_i) begin
        st_d = '0;
      end
    end
  end

  assign cmd_valid_o = accept && (last_byte_i || (s.add != '0));
  assign cmd_o       = '{last: last_byte_i, add: s.add};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ----- hw/rtl/twd_fifo.sv -----
// short queue of column commands between decoder and accumulator
module twd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  twd_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output twd_pkg::cmd_t out_cmd_o
);
  import twd_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign in_ready_o  = (cnt_q != CNT_BITS'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = entry_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ----- hw/rtl/twd_back.sv -----
// column accumulator with saturation and output register
module twd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  twd_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [twd_pkg::OUT_BITS-1:0]  out_width_o
);
  import twd_pkg::*;

  logic [WIDTH_COUNT_BITS-1:0] total_q, total_d;
  logic [WIDTH_COUNT_BITS:0]   sum;
  logic [WIDTH_COUNT_BITS-1:0] sat;
  logic                        valid_q, valid_d;
  logic [OUT_BITS-1:0]         width_q, width_d;
  logic                        pop;

  assign cmd_ready_o = !valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign sum         = {1'b0, total_q} + (WIDTH_COUNT_BITS + 1)'(cmd_i.add);
  assign sat         = sum[WIDTH_COUNT_BITS] ? '1 : sum[WIDTH_COUNT_BITS-1:0];

  always_comb begin
    total_d = total_q;
    valid_d = valid_q && !out_ready_i;
    width_d = width_q;
    if (pop) begin
      if (cmd_i.last) begin
        total_d = '0;
        valid_d = 1'b1;
        width_d = OUT_BITS'(sat);
      end else begin
        total_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
  end

  assign out_valid_o = valid_q;
  assign out_width_o = width_q;

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_i.last |=> total_q == '0)
    else $error("total not cleared after end of string");

  a_result_follows_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_i.last |=> valid_q)
    else $error("no result after end of string");

  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |-> !pop)
    else $error("command taken while result held");

endmodule

// ----- hw/rtl/terminal_display_width.sv -----
// top level of the terminal display width block
// usage:
//   input stream: one string byte per item in s_axis_tdata_i; s_axis_tuser_i
//   says the byte is present, s_axis_tlast_i ends the string. an item with
//   tuser low and tlast high only ends the string.
//   output stream: one item per string, the column count in m_axis_tdata_o,
//   saturating at the counter maximum.
//   throughput: one input item per cycle, every cycle, while the queue has room.
//   path: the result of a string passes through the queue entry, then the
//   accumulator output register; queued commands ahead of it are taken
//   first, and a held result delays it.
//   escape sequences, utf-8 decoding and cluster joining are resolved in the
//   decoder; the accumulator only adds per-item column counts.
// reset: all state returns to plain text mode with a zero count; no result
//   is pending after reset.
// stall: a held result stops the accumulator, the queue then fills and
//   s_axis_tready_o drops; no item is lost or repeated.
module terminal_display_width (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tuser_i,   // byte_present
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // display_width
);
  import twd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  twd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .text_byte_i    (s_axis_tdata_i),
    .byte_present_i (s_axis_tuser_i),
    .last_byte_i    (s_axis_tlast_i),
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (front_ready),
    .cmd_o          (front_cmd)
  );

  twd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_cmd_o   (back_cmd)
  );

  twd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_width_o (m_axis_tdata_o)
  );

endmodule

// ----- tb/tb_terminal_display_width.sv -----
// testbench for terminal_display_width: directed and random strings against a predictor
`timescale 1ns / 100ps

module tb_terminal_display_width;
  import twd_pkg::*;

  typedef struct {
    logic [7:0]  b;
    bit          pres;
    bit          last;
    bit          fixed;
    logic [23:0] fval;
  } text_item_t;

  localparam int unsigned RAND_ITEMS = 1450;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned QUIET_FROM = 1300;
  localparam logic [20:0] REPL_CP = 21'h3F;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;

  terminal_display_width dut (.*);

  // zero and wide code point ranges, lo/hi pairs
  int unsigned zero_tbl[$] = '{
    'h0000,'h001F, 'h200B,'h200F, 'h2028,'h202E, 'h2060,'h2064, 'hFEFF,'hFEFF,
    'hFFF9,'hFFFB, 'hE0100,'hE01EF,
    'h0300,'h036F, 'h0483,'h0489, 'h0591,'h05BD, 'h0610,'h061A, 'h064B,'h065F,
    'h0670,'h0670, 'h06D6,'h06DC, 'h06DF,'h06E4, 'h06E7,'h06E8, 'h06EA,'h06ED,
    'h0711,'h0711, 'h0730,'h074A, 'h07A6,'h07B0, 'h0900,'h0902, 'h093A,'h093C,
    'h0941,'h0948, 'h0951,'h0957, 'h0962,'h0963, 'h0981,'h0981, 'h09BC,'h09BC,
    'h09C1,'h09C4, 'h09CD,'h09CD, 'h09E2,'h09E3, 'h0A01,'h0A02, 'h0A3C,'h0A3C,
    'h0A41,'h0A42, 'h0A47,'h0A48, 'h0A4B,'h0A4D, 'h0A70,'h0A71, 'h0A81,'h0A82,
    'h0ABC,'h0ABC, 'h0AC1,'h0AC5, 'h0AC7,'h0AC8, 'h0ACD,'h0ACD, 'h0AE2,'h0AE3,
    'h0B01,'h0B01, 'h0B3C,'h0B3C, 'h0B3F,'h0B3F, 'h0B41,'h0B44, 'h0B4D,'h0B4D,
    'h0B56,'h0B56, 'h0B62,'h0B63, 'h0B82,'h0B82, 'h0BC0,'h0BC0, 'h0BCD,'h0BCD,
    'h0C3E,'h0C40, 'h0C46,'h0C48, 'h0C4A,'h0C4D, 'h0C55,'h0C56, 'h0C62,'h0C63,
    'h0CBC,'h0CBC, 'h0CBF,'h0CBF, 'h0CC6,'h0CC6, 'h0CCC,'h0CCD, 'h0CE2,'h0CE3,
    'h0D41,'h0D44, 'h0D4D,'h0D4D, 'h0D62,'h0D63, 'h0DCA,'h0DCA, 'h0DD2,'h0DD4,
    'h0DD6,'h0DD6, 'h0E31,'h0E31, 'h0E34,'h0E3A, 'h0E47,'h0E4E, 'h0EB1,'h0EB1,
    'h0EB4,'h0EB9, 'h0EBB,'h0EBC, 'h0EC8,'h0ECD, 'h0F18,'h0F19, 'h0F35,'h0F35,
    'h0F37,'h0F37, 'h0F39,'h0F39, 'h0F71,'h0F7E, 'h0F80,'h0F84, 'h0F86,'h0F87,
    'h0F90,'h0F97, 'h0F99,'h0FBC, 'h0FC6,'h0FC6, 'h102D,'h1030, 'h1032,'h1037,
    'h1039,'h103A, 'h103D,'h103E, 'h1058,'h1059, 'h105E,'h1060, 'h1071,'h1074,
    'h1082,'h1082, 'h1085,'h1086, 'h108D,'h108D, 'h109D,'h109D, 'h135D,'h135F,
    'h1712,'h1714, 'h1732,'h1734, 'h1752,'h1753, 'h1772,'h1773, 'h17B4,'h17B5,
    'h17B7,'h17BD, 'h17C6,'h17C6, 'h17C9,'h17D3, 'h17DD,'h17DD, 'h180B,'h180D,
    'h1885,'h1886, 'h18A9,'h18A9, 'h1920,'h1922, 'h1927,'h1928, 'h1932,'h1932,
    'h1939,'h193B, 'h1A17,'h1A18, 'h1A56,'h1A56, 'h1A58,'h1A5E, 'h1A60,'h1A60,
    'h1A62,'h1A62, 'h1A65,'h1A6C, 'h1A73,'h1A7C, 'h1A7F,'h1A7F, 'h1B00,'h1B03,
    'h1B34,'h1B34, 'h1B36,'h1B3A, 'h1B3C,'h1B3C, 'h1B42,'h1B42, 'h1B6B,'h1B73,
    'h1B80,'h1B81, 'h1BA2,'h1BA5, 'h1BA8,'h1BA9, 'h1BAB,'h1BAD, 'h1BE6,'h1BE6,
    'h1BE8,'h1BE9, 'h1BED,'h1BED, 'h1BEF,'h1BF1, 'h1C2C,'h1C33, 'h1C36,'h1C37,
    'h1CD0,'h1CD2, 'h1CD4,'h1CE0, 'h1CE2,'h1CE8, 'h1CED,'h1CED, 'h1CF4,'h1CF4,
    'h1DC0,'h1DFF, 'h20D0,'h20F0, 'h2CEF,'h2CF1, 'h2D7F,'h2D7F, 'h2DE0,'h2DFF,
    'hA66F,'hA672, 'hA674,'hA67D, 'hA69E,'hA69F, 'hA6F0,'hA6F1, 'hA802,'hA802,
    'hA806,'hA806, 'hA80B,'hA80B, 'hA825,'hA826, 'hA8C4,'hA8C5, 'hA8E0,'hA8F1,
    'hA926,'hA92D, 'hA947,'hA951, 'hA980,'hA982, 'hA9B3,'hA9B3, 'hA9B6,'hA9B9,
    'hA9BC,'hA9BC, 'hAA29,'hAA2E, 'hAA31,'hAA32, 'hAA35,'hAA36, 'hAA43,'hAA43,
    'hAA4C,'hAA4C, 'hAAB0,'hAAB0, 'hAAB2,'hAAB4, 'hAAB7,'hAAB8, 'hAABE,'hAABF,
    'hAAC1,'hAAC1, 'hAAEC,'hAAED, 'hAAF6,'hAAF6, 'hABE5,'hABE5, 'hABE8,'hABE8,
    'hABED,'hABED, 'hFB1E,'hFB1E, 'hFE00,'hFE0F, 'hFE20,'hFE2F
  };
  int unsigned wide_tbl[$] = '{
    'h1100,'h115F, 'h2329,'h232A, 'h2E80,'h303E, 'h3041,'h33BF, 'h3400,'h4DBF,
    'h4E00,'hA4CF, 'hA960,'hA97C, 'hAC00,'hD7A3, 'hF900,'hFAFF, 'hFE10,'hFE19,
    'hFE30,'hFE6F, 'hFF01,'hFF60, 'hFFE0,'hFFE6, 'h1B000,'h1B2FF, 'h1F000,'h1FAFF,
    'h20000,'h2FFFD, 'h30000,'h3FFFD
  };

  // directed rows: byte, present, last, fixed, expected width
  text_item_t dir_tbl[$] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 24'd0},
    '{8'h41, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 24'd0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 24'd1},
    '{8'h00, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 24'd1},
    '{8'h1B, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h5B, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h6D, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h41, 1'b1, 1'b1, 1'b1, 24'd1},
    '{8'h1B, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h5D, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h07, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h78, 1'b1, 1'b1, 1'b1, 24'd1},
    '{8'h1B, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h61, 1'b1, 1'b1, 1'b1, 24'd1},
    '{8'hE4, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'hB8, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 24'd2},
    '{8'hC0, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 24'd2},
    '{8'hE2, 1'b1, 1'b0, 1'b0, 24'd0},
    '{8'h82, 1'b1, 1'b1, 1'b1, 24'd2}
  };

  // predictor state
  logic [2:0]      esc_st;
  logic [20:0]     part_cp;
  int unsigned     cont_need;
  int unsigned     seq_taken;
  bit              cl_open;
  int unsigned     base_w;
  bit              joined;
  bit              ri_wait;
  bit              ri_pair;
  bit              post_zwj;
  longint unsigned col_sum;

  text_item_t  stim_q[$];
  logic [7:0]  tok_q[$];
  logic [23:0] width_q[$];
  int unsigned in_count;
  int unsigned out_count;
  int unsigned str_count;
  int unsigned err_count;
  int unsigned idle_cycles;
  bit          quiet;
  bit          long_done;
  int unsigned hold_cnt;

  function automatic bit span_hit(int unsigned u, ref int unsigned tbl[$]);
    for (int i = 0; i < tbl.size(); i += 2)
      if (u >= tbl[i] && u <= tbl[i+1]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned cp_columns(int unsigned u);
    if (span_hit(u, zero_tbl)) return 0;
    if (span_hit(u, wide_tbl)) return 2;
    return 1;
  endfunction

  function automatic bit is_flag(int unsigned u);
    return u >= REGIONAL_LO && u <= REGIONAL_HI;
  endfunction

  function automatic bit is_modifier(int unsigned u);
    return (u >= VSEL_LO && u <= VSEL_HI) || (u >= SKIN_LO && u <= SKIN_HI);
  endfunction

  function void clear_text();
    esc_st = MODE_TEXT;
    part_cp = '0;
    cont_need = 0;
    seq_taken = 0;
    cl_open = 0;
    base_w = 0;
    joined = 0;
    ri_wait = 0;
    ri_pair = 0;
    post_zwj = 0;
    col_sum = 0;
  endfunction

  function void close_cluster();
    longint unsigned t;
    t = col_sum + ((joined || ri_pair) ? 2 : base_w);
    col_sum = (t > 64'hFF_FFFF) ? 64'hFF_FFFF : t;
    cl_open = 0;
    base_w = 0;
    joined = 0;
    ri_wait = 0;
    ri_pair = 0;
    post_zwj = 0;
  endfunction

  function void add_unit(int unsigned u);
    if (cl_open) begin
      if (post_zwj) begin
        post_zwj = 0;
        ri_wait = 0;
        return;
      end
      if (ri_wait) begin
        ri_wait = 0;
        if (is_flag(u)) begin
          ri_pair = 1;
          return;
        end
      end
      if (is_modifier(u)) return;
      if (u == ZWJ_CP) begin
        joined = 1;
        post_zwj = 1;
        return;
      end
      close_cluster();
    end
    cl_open = 1;
    base_w = cp_columns(u);
    ri_wait = is_flag(u);
    ri_pair = 0;
    joined = 0;
    post_zwj = 0;
  endfunction

  function void flush_bad(int unsigned n);
    part_cp = '0;
    cont_need = 0;
    seq_taken = 0;
    for (int k = 0; k < n; k++) add_unit(32'(REPL_CP));
  endfunction

  function void decode_text(logic [7:0] b);
    int unsigned len;
    int unsigned floor_cp;
    int unsigned c;
    if (cont_need != 0) begin
      if (b[7:6] == 2'b10) begin
        part_cp = {part_cp[14:0], b[5:0]};
        cont_need--;
        if (cont_need == 0) begin
          len = seq_taken + 1;
          c = 32'(part_cp);
          floor_cp = (len == 2) ? 'h80 : (len == 3) ? 'h800 : 'h10000;
          if (c >= floor_cp && c <= CP_MAX && !(c >= SURR_LO && c <= SURR_HI)) begin
            part_cp = '0;
            seq_taken = 0;
            add_unit(c);
          end else begin
            flush_bad(len);
          end
        end else begin
          seq_taken++;
        end
        return;
      end
      flush_bad(seq_taken);
    end
    if (b < 8'h80) begin
      if (b == ESC_CHAR && !(cl_open && post_zwj)) begin
        if (cl_open) close_cluster();
        esc_st = MODE_ESC;
      end else begin
        add_unit(32'(b));
      end
    end else if (b < 8'hC0 || b >= 8'hF8) begin
      add_unit(32'(REPL_CP));
    end else begin
      seq_taken = 1;
      if (b < 8'hE0) begin
        part_cp = 21'(b[4:0]);
        cont_need = 1;
      end else if (b < 8'hF0) begin
        part_cp = 21'(b[3:0]);
        cont_need = 2;
      end else begin
        part_cp = 21'(b[2:0]);
        cont_need = 3;
      end
    end
  endfunction

  function void osc_byte(logic [7:0] b);
    if (b == BEL_CHAR) esc_st = MODE_TEXT;
    else if (b == ESC_CHAR) esc_st = MODE_OSC_ESC;
    else esc_st = MODE_OSC;
  endfunction

  function void feed_byte(logic [7:0] b);
    case (esc_st)
      MODE_ESC: begin
        if (b == CSI_CHAR) esc_st = MODE_CSI;
        else if (b == OSC_CHAR) esc_st = MODE_OSC;
        else begin
          esc_st = MODE_TEXT;
          add_unit(32'(ESC_CHAR));
          decode_text(b);
        end
      end
      MODE_CSI: begin
        if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) esc_st = MODE_TEXT;
      end
      MODE_OSC: osc_byte(b);
      MODE_OSC_ESC: begin
        if (b == ST_CHAR) esc_st = MODE_TEXT;
        else osc_byte(b);
      end
      default: begin
        esc_st = MODE_TEXT;
        decode_text(b);
      end
    endcase
  endfunction

  function logic [23:0] finish_string();
    logic [23:0] w;
    if (esc_st == MODE_ESC) begin
      esc_st = MODE_TEXT;
      add_unit(32'(ESC_CHAR));
    end
    if (cont_need != 0) flush_bad(seq_taken);
    if (cl_open) close_cluster();
    w = col_sum[23:0];
    clear_text();
    return w;
  endfunction

  function void put_tok(logic [7:0] b);
    tok_q.insert(tok_q.size(), b);
  endfunction

  function void push_cont(int n);
    for (int i = 0; i < n; i++) put_tok(8'(8'h80 | $urandom_range(0, 63)));
  endfunction

  // one random piece of text: mostly well-formed, some broken or noise
  function void push_token();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: put_tok(8'($urandom_range(32, 126)));
      3: put_tok(8'($urandom_range(0, 31)));
      4: begin
        put_tok(8'($urandom_range('hE4, 'hE9)));
        push_cont(2);
      end
      5: begin
        put_tok(8'hF0); put_tok(8'h9F);
        put_tok(8'($urandom_range('h98, 'h9A)));
        push_cont(1);
      end
      6: begin
        put_tok(8'hF0); put_tok(8'h9F); put_tok(8'h87);
        put_tok(8'($urandom_range('hA6, 'hBF)));
      end
      7: begin
        put_tok(8'hEF); put_tok(8'hB8);
        put_tok(8'($urandom_range('h80, 'h8F)));
      end
      8: begin
        put_tok(8'hE2); put_tok(8'h80); put_tok(8'h8D);
      end
      9: begin
        put_tok(8'hF0); put_tok(8'h9F); put_tok(8'h8F);
        put_tok(8'($urandom_range('hBB, 'hBF)));
      end
      10: begin
        put_tok(8'($urandom_range('hC2, 'hDF)));
        push_cont(1);
      end
      11: begin
        put_tok(8'($urandom_range('hE0, 'hEF)));
        push_cont(2);
      end
      12: begin
        put_tok(ESC_CHAR); put_tok(CSI_CHAR);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) put_tok(8'($urandom_range('h30, 'h3F)));
        put_tok(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
      end
      13: begin
        put_tok(ESC_CHAR); put_tok(OSC_CHAR);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) put_tok(8'($urandom_range(32, 255)));
        if ($urandom_range(0, 1)) put_tok(BEL_CHAR);
        else begin
          put_tok(ESC_CHAR); put_tok(ST_CHAR);
        end
      end
      14: begin
        put_tok(ESC_CHAR);
        put_tok(8'($urandom_range(0, 255)));
      end
      15: put_tok(8'($urandom_range(0, 255)));
      16: begin
        // cut short, overlong, surrogate or beyond the top code point
        case ($urandom_range(0, 3))
          0: begin
            put_tok(8'($urandom_range('hC0, 'hF7)));
            put_tok(8'($urandom_range(0, 127)));
          end
          1: begin
            put_tok(8'($urandom_range('hC0, 'hC1)));
            push_cont(1);
          end
          2: begin
            put_tok(8'hED);
            put_tok(8'($urandom_range('hA0, 'hBF)));
            push_cont(1);
          end
          default: begin
            put_tok(8'($urandom_range('hF4, 'hF7)));
            put_tok(8'($urandom_range('h90, 'hBF)));
            push_cont(2);
          end
        endcase
      end
      17: begin
        put_tok(8'($urandom_range('hF0, 'hF4)));
        push_cont(3);
      end
      18: begin
        put_tok(8'hCC);
        push_cont(1);
      end
      default: begin
        put_tok(8'($urandom_range('hEA, 'hED)));
        put_tok(8'($urandom_range('h80, 'h9F)));
        push_cont(1);
      end
    endcase
  endfunction

  function void build_random();
    text_item_t it;
    int ntok;
    it.fixed = 0;
    it.fval = '0;
    while (stim_q.size() < RAND_ITEMS + 25) begin
      tok_q.delete();
      ntok = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < ntok; i++) push_token();
      foreach (tok_q[i]) begin
        if ($urandom_range(0, 24) == 0) begin
          it.b = 8'($urandom_range(0, 255)); it.pres = 0; it.last = 0;
          stim_q.insert(stim_q.size(), it);
        end
        it.b = tok_q[i]; it.pres = 1; it.last = 0;
        stim_q.insert(stim_q.size(), it);
      end
      if (tok_q.size() != 0 && $urandom_range(0, 4) != 0) stim_q[$].last = 1;
      else begin
        it.b = 8'($urandom_range(0, 255)); it.pres = 0; it.last = 1;
        stim_q.insert(stim_q.size(), it);
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // acceptance monitor, predictor and result check
  always @(posedge clk_i) begin
    logic [23:0] want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_count <= in_count + 1;
        if (s_axis_tuser_i) feed_byte(s_axis_tdata_i);
        if (s_axis_tlast_i) begin
          want = finish_string();
          if (stim_q[in_count].fixed) want = stim_q[in_count].fval;
          width_q.insert(width_q.size(), want);
          str_count <= str_count + 1;
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_count <= out_count + 1;
        if (width_q.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10) $display("unexpected result width %0d", m_axis_tdata_o);
        end else begin
          want = width_q.pop_front();
          if (m_axis_tdata_o !== want) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display("width mismatch on string %0d: expected %0d, got %0d",
                       out_count, want, m_axis_tdata_o);
          end
        end
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!long_done && in_count >= 400) begin
      long_done <= 1'b1;
      hold_cnt <= 60;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && in_count / 200 % 2 == 0 && $urandom_range(0, 5) == 0) begin
      hold_cnt <= $urandom_range(0, 2);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("** terminal_display_width: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    clear_text();
    in_count = 0;
    out_count = 0;
    str_count = 0;
    err_count = 0;
    idle_cycles = 0;
    quiet = 0;
    long_done = 0;
    hold_cnt = 0;
    stim_q = dir_tbl;
    build_random();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stim_q[i]) begin
      if (i >= QUIET_FROM) quiet = 1;
      if (!quiet && (i / 150) % 2 == 1 && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 3);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= stim_q[i].b;
      s_axis_tuser_i <= stim_q[i].pres;
      s_axis_tlast_i <= stim_q[i].last;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (width_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("sent %0d items forming %0d strings, checked %0d widths, %0d mismatches",
             in_count, str_count, out_count, err_count);
    $display("strings mixed text, wide and joined emoji, escapes and broken utf-8");
    if (err_count == 0 && width_q.size() == 0) begin
      $display("** terminal_display_width: PASSED **");
    end else begin
      $display("** terminal_display_width: FAILED **");
    end
    $finish;
  end

endmodule
